// ----- rtl/swmm_pkg.sv -----
package swmm_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 32;

  // sample positions wrap modulo 2^32
  localparam int POS_BITS = 32;

  localparam int CFG_BITS = 7;
  localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRONT,
    ST_BACK
  } swmm_state_t;

  // result flags handed combinationally from the sequencer to the output register
  typedef struct packed {
    logic valid;
    logic full;
    logic done;
  } swmm_res_flags_t;

endpackage

// ----- rtl/swmm_cand_mem.sv -----
module swmm_cand_mem #(
  parameter int DEPTH = swmm_pkg::MAX_WINDOW_DEF,
  parameter int VAL_W = swmm_pkg::SAMPLE_BITS_DEF,
  parameter int POS_W = swmm_pkg::POS_BITS,
  parameter int IDX_W = $clog2(swmm_pkg::MAX_WINDOW_DEF)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [VAL_W-1:0] wvalue,
  input  logic [POS_W-1:0] wpos,
  input  logic [IDX_W-1:0] raddr,
  output logic [VAL_W-1:0] rvalue,
  output logic [POS_W-1:0] rpos
);
  import swmm_pkg::*;

  logic [VAL_W+POS_W-1:0] mem [DEPTH];
  logic [VAL_W+POS_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wvalue, wpos};
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

  assign rvalue = rdata[VAL_W+POS_W-1:POS_W];
  assign rpos   = rdata[POS_W-1:0];

endmodule

// ----- rtl/swmm_ctrl.sv -----
module swmm_ctrl #(
  parameter int MAX_WINDOW  = swmm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swmm_pkg::SAMPLE_BITS_DEF,
  parameter int IDX_W       = $clog2(swmm_pkg::MAX_WINDOW_DEF),
  parameter int K_W         = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [K_W-1:0]                win_k,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_BITS-1:0]        in_sample,
  input  logic                          in_last,
  input  logic                          out_free,
  output swmm_pkg::swmm_res_flags_t     res_flags,
  output logic [SAMPLE_BITS-1:0]        res_max,
  output logic [SAMPLE_BITS-1:0]        res_min,
  output logic                          mem_we,
  output logic [IDX_W-1:0]              mem_waddr,
  output logic [SAMPLE_BITS-1:0]        mem_wvalue,
  output logic [swmm_pkg::POS_BITS-1:0] mem_wpos,
  output logic [IDX_W-1:0]              mem_raddr,
  input  logic [SAMPLE_BITS-1:0]        mem_rvalue,
  input  logic [swmm_pkg::POS_BITS-1:0] mem_rpos
);
  import swmm_pkg::*;

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_WINDOW - 1);
  localparam logic [SAMPLE_BITS-1:0] MAX_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  swmm_state_t state, state_next;

  logic [IDX_W-1:0]       head;
  logic [IDX_W-1:0]       tail;
  logic [CNT_W-1:0]       count;
  logic [POS_BITS-1:0]    pos;
  logic [SAMPLE_BITS-1:0] run_min;
  logic [SAMPLE_BITS-1:0] smp;
  logic                   last;
  logic [SAMPLE_BITS-1:0] front_val;

  logic [IDX_W-1:0]       head_inc, tail_inc, tail_dec, tail_dec2;
  logic [POS_BITS-1:0]    age;
  logic                   front_pop, back_pop, finish, accept;
  logic [SAMPLE_BITS-1:0] cur_max, new_min;
  logic                   full;

  assign head_inc  = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign tail_inc  = (tail == LAST_IDX) ? '0 : tail + 1'b1;
  assign tail_dec  = (tail == '0) ? LAST_IDX : tail - 1'b1;
  assign tail_dec2 = (tail_dec == '0) ? LAST_IDX : tail_dec - 1'b1;

  // age of the oldest candidate, modulo 2^32
  assign age = pos - mem_rpos;

  assign accept    = (state == ST_IDLE) && in_valid;
  assign front_pop = (state == ST_FRONT) && (count != '0) &&
                     (age >= {{(POS_BITS-K_W){1'b0}}, win_k});
  assign back_pop  = (state == ST_BACK) && (count != '0) &&
                     ($signed(mem_rvalue) <= $signed(smp));
  assign finish    = (state == ST_BACK) && !back_pop && out_free;

  // empty queue after the drops means the new sample is the front
  assign cur_max = (count == '0) ? smp : front_val;
  assign full    = ({1'b0, pos} + 1'b1) >= {{(POS_BITS+1-K_W){1'b0}}, win_k};
  assign new_min = (full && ($signed(cur_max) < $signed(run_min))) ? cur_max : run_min;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_FRONT;
      ST_FRONT: if (!front_pop) state_next = ST_BACK;
      ST_BACK:  if (finish) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    mem_we    = finish;
    mem_raddr = head;
    unique case (state)
      ST_IDLE:  mem_raddr = head;
      ST_FRONT: mem_raddr = front_pop ? head_inc : tail_dec;
      ST_BACK:  mem_raddr = back_pop ? tail_dec2 : tail_dec;
      default:  mem_raddr = head;
    endcase
  end

  assign mem_waddr  = tail;
  assign mem_wvalue = smp;
  assign mem_wpos   = pos;

  assign res_flags.valid = finish;
  assign res_flags.full  = full;
  assign res_flags.done  = last;
  assign res_max         = cur_max;
  assign res_min         = new_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      head    <= '0;
      tail    <= '0;
      count   <= '0;
      pos     <= '0;
      run_min <= MAX_POS;
    end else begin
      state <= state_next;
      if (front_pop) begin
        head  <= head_inc;
        count <= count - 1'b1;
      end
      if (back_pop) begin
        tail  <= tail_dec;
        count <= count - 1'b1;
      end
      if (finish) begin
        if (last) begin
          head    <= '0;
          tail    <= '0;
          count   <= '0;
          pos     <= '0;
          run_min <= MAX_POS;
        end else begin
          tail    <= tail_inc;
          count   <= count + 1'b1;
          pos     <= pos + 1'b1;
          run_min <= new_min;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp  <= in_sample;
      last <= in_last;
    end
    // surviving oldest candidate
    if ((state == ST_FRONT) && !front_pop) begin
      front_val <= mem_rvalue;
    end
  end

endmodule

// ----- rtl/sliding_window_max_min_tracker_unit.sv -----
// Sliding window maximum with a running minimum of the full-window maxima.
// Each sample request on the s_ side gives one result on the m_ side: the
// maximum of the last window_size samples, a window-full flag, the running
// minimum of full-window maxima (largest positive value until a window is
// full) and tlast echoed; a sample with tlast set ends the sequence and the
// tracker starts afresh, window_size is kept. The user must write window_size
// through cfg_wr_en/cfg_wr_data only while the block is idle (the block does
// not enforce it); 0 acts as 1 and values above MAX_WINDOW saturate. A ring
// in a one-port-read memory holds the candidates; aged ones leave the front,
// ones not above the sample the back, each at most once, and the sample is
// written once the output is free; only then is the next sample taken, even
// while a result waits in the output register. Reset needs no clearing pass.
module sliding_window_max_min_tracker_unit #(
  parameter int MAX_WINDOW  = swmm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swmm_pkg::SAMPLE_BITS_DEF,
  parameter int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  parameter int OUT_TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [swmm_pkg::CFG_BITS-1:0] cfg_wr_data,   // window_size
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [IN_TDATA_W-1:0]         s_tdata,       // sample_value
  input  logic                          s_tlast,       // end_of_sequence
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [OUT_TDATA_W-1:0]        m_tdata,       // window_max, min_of_maxima
  output logic                          m_tuser,       // window_full
  output logic                          m_tlast        // sequence_done
);
  import swmm_pkg::*;

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int K_W   = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;

  logic [CFG_BITS-1:0]    window_size;
  logic [K_W-1:0]         ws_ext, win_k;

  swmm_res_flags_t        res_flags;
  logic [SAMPLE_BITS-1:0] res_max, res_min;
  logic                   out_free;

  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr, mem_raddr;
  logic [SAMPLE_BITS-1:0] mem_wvalue, mem_rvalue;
  logic [POS_BITS-1:0]    mem_wpos, mem_rpos;

  logic [SAMPLE_BITS-1:0] out_max, out_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      window_size <= cfg_wr_data;
    end
  end

  assign ws_ext = K_W'(window_size);
  assign win_k  = (ws_ext == '0) ? K_W'(1) :
                  (ws_ext > K_W'(MAX_WINDOW)) ? K_W'(MAX_WINDOW) : ws_ext;

  assign out_free = !m_tvalid || m_tready;

  swmm_ctrl #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IDX_W       (IDX_W),
    .K_W         (K_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .win_k      (win_k),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_sample  (s_tdata[SAMPLE_BITS-1:0]),
    .in_last    (s_tlast),
    .out_free   (out_free),
    .res_flags  (res_flags),
    .res_max    (res_max),
    .res_min    (res_min),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wvalue (mem_wvalue),
    .mem_wpos   (mem_wpos),
    .mem_raddr  (mem_raddr),
    .mem_rvalue (mem_rvalue),
    .mem_rpos   (mem_rpos)
  );

  swmm_cand_mem #(
    .DEPTH (MAX_WINDOW),
    .VAL_W (SAMPLE_BITS),
    .POS_W (POS_BITS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wvalue (mem_wvalue),
    .wpos   (mem_wpos),
    .raddr  (mem_raddr),
    .rvalue (mem_rvalue),
    .rpos   (mem_rpos)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_flags.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_flags.valid) begin
      out_max <= res_max;
      out_min <= res_min;
      m_tuser <= res_flags.full;
      m_tlast <= res_flags.done;
    end
  end

  assign m_tdata = OUT_TDATA_W'({out_min, out_max});

endmodule

// ----- sim/sliding_window_max_min_tracker_unit_test.sv -----
`timescale 1ns / 1ps

module sliding_window_max_min_tracker_unit_test;

  localparam int DEPTH         = swmm_pkg::MAX_WINDOW_DEF;
  localparam int RANDOM_ITEMS  = 1150;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int DRAIN_CYCLES  = 80;
  localparam int IDLE_PERCENT  = 23;

  typedef struct {
    logic signed [31:0] max_val;
    logic               full;
    logic signed [31:0] min_val;
    logic               done;
  } window_result_t;

  // tracks the candidate deque and the running minimum for each sample
  class window_max_scoreboard;
    logic [6:0]         window_reg;
    logic signed [31:0] cand_val[$];
    logic [31:0]        cand_pos[$];
    logic [31:0]        position;
    logic signed [31:0] run_min;
    window_result_t     expected_q[$];
    int                 errors;

    function new();
      window_reg = swmm_pkg::WINDOW_RESET;
      errors = 0;
      clear_sequence();
    endfunction

    function void clear_sequence();
      cand_val.delete();
      cand_pos.delete();
      position = '0;
      run_min = 32'sh7fffffff;
    endfunction

    function void set_window(logic [6:0] w);
      window_reg = w;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_sample(logic signed [31:0] v, logic eos);
      logic [6:0]     eff;
      window_result_t r;
      eff = (window_reg == 0) ? 7'd1 : (window_reg > DEPTH) ? 7'(DEPTH) : window_reg;
      // ages are taken modulo 2^32
      while (cand_val.size() > 0 && (position - cand_pos[0]) >= {25'd0, eff}) begin
        cand_val.delete(0);
        cand_pos.delete(0);
      end
      // a tie keeps the newer sample
      while (cand_val.size() > 0 && cand_val[$] <= v) begin
        cand_val.delete(cand_val.size() - 1);
        cand_pos.delete(cand_pos.size() - 1);
      end
      cand_val.insert(cand_val.size(), v);
      cand_pos.insert(cand_pos.size(), position);
      r.max_val = cand_val[0];
      r.full = ({1'b0, position} + 33'd1) >= {26'd0, eff};
      if (r.full && r.max_val < run_min)
        run_min = r.max_val;
      r.min_val = run_min;
      r.done = eos;
      expected_q.insert(expected_q.size(), r);
      position = position + 32'd1;
      if (eos)
        clear_sequence();
    endfunction

    function void check_result(logic [63:0] data, logic full, logic done);
      window_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected: max %0d min %0d full %0b last %0b",
                 $time, $signed(data[31:0]), $signed(data[63:32]), full, done);
        errors++;
        return;
      end
      e = expected_q[0];
      expected_q.delete(0);
      if (data[31:0] !== e.max_val) begin
        $display("%0t: window_max expected %0d, got %0d", $time, e.max_val,
                 $signed(data[31:0]));
        errors++;
      end
      if (full !== e.full) begin
        $display("%0t: window_full expected %0b, got %0b", $time, e.full, full);
        errors++;
      end
      if (data[63:32] !== e.min_val) begin
        $display("%0t: min_of_maxima expected %0d, got %0d", $time, e.min_val,
                 $signed(data[63:32]));
        errors++;
      end
      if (done !== e.done) begin
        $display("%0t: sequence_done expected %0b, got %0b", $time, e.done, done);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [6:0]  cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  window_max_scoreboard sb;
  int          cycle_count = 0;
  bit          no_idle = 1'b0;
  int          seq_left = 0;
  int          seq_mode = 0;
  logic [31:0] last_value = '0;

  sliding_window_max_min_tracker_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && m_tvalid && m_tready)
      sb.check_result(m_tdata, m_tuser, m_tlast);
  end

  task automatic send_sample(input logic [31:0] v, input logic eos);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= eos;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(v, eos);
  endtask

  // drop the request line and wait for every outstanding result
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [6:0] w);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_window(w);
  endtask

  function automatic logic [6:0] pick_window();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 7'($urandom_range(1, 8));
    if (r < 70) return 7'($urandom_range(9, DEPTH));
    if (r < 80) return 7'(DEPTH);
    if (r < 87) return 7'd0;
    if (r < 94) return 7'($urandom_range(DEPTH + 1, 127));
    return 7'd1;
  endfunction

  function automatic logic [31:0] next_value();
    case (seq_mode)
      0: return $urandom;
      1: return 32'($urandom_range(0, 6)) - 32'd3;
      // falling walk fills the deque, rising walk empties it from the back
      2: return last_value - 32'($urandom_range(0, 2));
      3: return ($urandom_range(15) == 0) ? $urandom : last_value + 32'($urandom_range(0, 2));
      default: begin
        case ($urandom_range(4))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h00000000;
          3: return 32'hffffffff;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  task automatic run_phase(inout int sent);
    int          n;
    logic [6:0]  w;
    logic [31:0] v;
    w = pick_window();
    write_window(w);
    n = (w == 0 || w > 16) ? $urandom_range(40, 160) : $urandom_range(20, 80);
    if (n > RANDOM_ITEMS - sent)
      n = RANDOM_ITEMS - sent;
    // the phase may stop mid-sequence, so the next window change lands inside one
    repeat (n) begin
      if (seq_left == 0) begin
        seq_left = $urandom_range(1, 3 * ((w == 0) ? 1 : (w > DEPTH) ? DEPTH : w) + 8);
        seq_mode = $urandom_range(4);
        last_value = $urandom;
      end
      no_idle = (sent >= 400 && sent < 600);
      v = next_value();
      last_value = v;
      send_sample(v, seq_left == 1);
      seq_left--;
      sent++;
    end
  endtask

  initial begin
    int sent;
    sb = new();
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tlast     <= 1'b0;
    m_tready    <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // window of two from reset: extremes, a tie and the end of a sequence
    send_sample(32'h7fffffff, 1'b0);
    send_sample(32'h80000000, 1'b0);
    send_sample(32'h00000000, 1'b0);
    send_sample(32'hffffffff, 1'b0);
    send_sample(32'd5, 1'b0);
    send_sample(32'd5, 1'b0);
    send_sample(32'd3, 1'b0);
    send_sample(32'd7, 1'b1);
    // zero acts as a window of one
    write_window(7'd0);
    send_sample(32'hffffffff, 1'b0);
    send_sample(32'h80000000, 1'b0);
    send_sample(32'h7fffffff, 1'b1);
    // above the deque depth saturates
    write_window(7'd127);
    send_sample(32'd9, 1'b0);
    send_sample(32'd8, 1'b0);
    send_sample(32'd8, 1'b0);
    send_sample(32'd7, 1'b1);
    // shrinking the window mid-sequence drops old candidates at once
    write_window(7'd3);
    send_sample(32'd6, 1'b0);
    send_sample(32'd2, 1'b0);
    send_sample(32'd1, 1'b0);
    write_window(7'd1);
    send_sample(32'h80000000, 1'b0);
    send_sample(32'd4, 1'b1);
    write_window(7'(DEPTH));
    send_sample(32'h80000001, 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS)
      run_phase(sent);
    no_idle = 1'b0;

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
